[src/lag_autocorrelation_detector_defines.svh]
// ----------------------------------------------------------------------------
// Lag autocorrelation detector assertion macros
// Concurrent check helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LAG_AUTOCORRELATION_DETECTOR_DEFINES_SVH
`define LAG_AUTOCORRELATION_DETECTOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define LAD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define LAD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LAD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define LAD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[src/lad_pkg.sv]
// ----------------------------------------------------------------------------
// Lag autocorrelation detector package
// Shared constants, register codes, command/status types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package lad_pkg;

   localparam int MAX_LAG      = 4096;
   localparam int LAG_AW       = $clog2(MAX_LAG);
   localparam int MAX_PRODUCTS = 1048576;

   // register indexes
   localparam logic [2:0] REG_LAG     = 3'd0;
   localparam logic [2:0] REG_COUNT   = 3'd1;
   localparam logic [2:0] REG_SETTLE  = 3'd2;
   localparam logic [2:0] REG_MIN_MAG = 3'd3;
   localparam logic [2:0] REG_MODE    = 3'd4;

   // normalization modes
   localparam logic [1:0] MODE_ABS_TOTAL  = 2'd0;
   localparam logic [1:0] MODE_ABS_PARTS  = 2'd1;
   localparam logic [1:0] MODE_ABS_MAGSUM = 2'd2;
   localparam logic [1:0] MODE_RE_MAGSUM  = 2'd3;

   typedef struct packed {
      logic [12:0] lag;
      logic [20:0] count;
      logic [23:0] settle;
      logic [15:0] min_mag;
      logic [1:0]  mode;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic restart;
      logic settle_dec;
      logic mem_access;
      logic warm_inc;
      logic mul1;
      logic mul2;
      logic cmp;
      logic sqrt_step;
      logic acc;
      logic eload;
      logic shift_step;
      logic emul;
      logic eadd;
      logic escale;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic restart;
      logic finished;
      logic settling;
      logic warmup;
      logic pass;
      logic last;
      logic shift_done;
      logic sqrt_done;
      logic den_zero;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic [12:0] eff_lag(input logic [12:0] lag);
      logic [12:0] r;
      if (lag == 13'd0) r = 13'd1;
      else if (lag > 13'(MAX_LAG)) r = 13'(MAX_LAG);
      else r = lag;
      return r;
   endfunction

   function automatic logic [20:0] eff_count(input logic [20:0] cnt);
      logic [20:0] r;
      if (cnt > 21'(MAX_PRODUCTS)) r = 21'(MAX_PRODUCTS);
      else r = cnt;
      return r;
   endfunction

endpackage
`default_nettype wire

[src/lad_ctrl.sv]
// ----------------------------------------------------------------------------
// Lag autocorrelation detector controller
// Sequences one item at a time through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module lad_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  lad_pkg::status_type status,
   output lad_pkg::cmd_type    cmd
);
   import lad_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_MUL1   = 4'd2;
   localparam logic [3:0] S_MUL2   = 4'd3;
   localparam logic [3:0] S_CMP    = 4'd4;
   localparam logic [3:0] S_SQRT   = 4'd5;
   localparam logic [3:0] S_ACC    = 4'd6;
   localparam logic [3:0] S_ELOAD  = 4'd7;
   localparam logic [3:0] S_SHIFT  = 4'd8;
   localparam logic [3:0] S_EMUL   = 4'd9;
   localparam logic [3:0] S_EADD   = 4'd10;
   localparam logic [3:0] S_ESQRT  = 4'd11;
   localparam logic [3:0] S_ESCALE = 4'd12;
   localparam logic [3:0] S_DIV    = 4'd13;
   localparam logic [3:0] S_OUT    = 4'd14;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            if (status.restart) begin
               cmd.restart = 1'b1;
            end else if (status.finished) begin
               state_in = S_IDLE;
            end else if (status.settling) begin
               cmd.settle_dec = 1'b1;
            end else begin
               cmd.mem_access = 1'b1;
               if (status.warmup) begin
                  cmd.warm_inc = 1'b1;
               end else begin
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (status.sqrt_done || !status.pass) begin
               state_in = S_ACC;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.last ? S_ELOAD : S_IDLE;
         end
         S_ELOAD: begin
            cmd.eload = 1'b1;
            state_in  = S_SHIFT;
         end
         S_SHIFT: begin
            if (status.shift_done) begin
               state_in = S_EMUL;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_EMUL: begin
            cmd.emul = 1'b1;
            state_in = S_EADD;
         end
         S_EADD: begin
            cmd.eadd = 1'b1;
            state_in = S_ESQRT;
         end
         S_ESQRT: begin
            if (status.sqrt_done) begin
               state_in = S_ESCALE;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
         end
         S_ESCALE: begin
            cmd.escale = 1'b1;
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (status.den_zero || status.div_done) begin
               state_in = S_OUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[src/lad_datapath.sv]
// ----------------------------------------------------------------------------
// Lag autocorrelation detector datapath
// Delay line, lagged product, shared square root, divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module lad_datapath (
   input  wire                 clock,
   input  wire                 reset,
   input  lad_pkg::cfg_type    cfg,
   input  lad_pkg::cmd_type    cmd,
   output lad_pkg::status_type status,
   input  wire  [15:0]         req_tdata,
   input  wire                 req_tuser,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [39:0]         rsp_tdata,
   output logic                rsp_tuser
);
   import lad_pkg::*;

   // captured item
   logic [7:0]  i_ff, q_ff;
   logic        restart_ff;
   // delay line
   logic [15:0] mem [MAX_LAG];
   logic [15:0] old_ff;
   logic [LAG_AW-1:0] wp_ff;
   // run state
   logic [20:0] count_ff;
   logic [23:0] settle_ff;
   logic        finished_ff;
   logic signed [37:0] sum_re_ff, sum_im_ff;
   logic [36:0] sum_mag_ff;
   logic [20:0] parts_ff;
   // product pipeline
   logic signed [16:0] re_ff, im_ff;
   logic [31:0] rr_ff, ii_ff, mm_ff;
   logic        pass_ff;
   // square root unit
   logic [63:0] sx_ff, sres_ff, sbit_ff;
   logic [5:0]  scnt_ff;
   // sum magnitude
   logic [37:0] ar_ff, ai_ff;
   logic [2:0]  sh_ff;
   logic [61:0] sqr_ff, sqi_ff;
   // divider
   logic [52:0] num_ff;
   logic [36:0] den_ff;
   logic [37:0] rem_ff;
   logic [5:0]  dcnt_ff;
   logic        neg_ff;
   // result register
   logic        rvalid_ff;
   logic [15:0] rcoef_ff;
   logic [20:0] rparts_ff;
   logic        rzero_ff;

   logic [12:0] lag;
   logic [20:0] ecount;
   logic [LAG_AW-1:0] rd_addr;
   logic [21:0] formed;
   logic signed [8:0] nr, ni, orr, oi;
   logic signed [33:0] rsq, isq;
   logic [63:0] s_trial;
   logic [37:0] rem_sh;
   logic [38:0] sabs;
   logic [37:0] abs_re, abs_im;
   logic [15:0] coef;

   assign lag     = eff_lag(cfg.lag);
   assign ecount  = eff_count(cfg.count);
   assign rd_addr = wp_ff - lag[LAG_AW-1:0];
   assign formed  = {1'b0, count_ff} - {9'b0, lag} + 22'd1;
   assign nr  = $signed({1'b0, i_ff}) - 9'sd127;
   assign ni  = $signed({1'b0, q_ff}) - 9'sd127;
   assign orr = $signed({1'b0, old_ff[15:8]}) - 9'sd127;
   assign oi  = $signed({1'b0, old_ff[7:0]}) - 9'sd127;
   assign rsq = re_ff * re_ff;
   assign isq = im_ff * im_ff;
   assign s_trial = sres_ff + sbit_ff;
   assign rem_sh  = {rem_ff[36:0], num_ff[52]};
   assign sabs    = {7'b0, sres_ff[31:0]} << sh_ff;
   assign abs_re  = sum_re_ff[37] ? 38'(-sum_re_ff) : 38'(sum_re_ff);
   assign abs_im  = sum_im_ff[37] ? 38'(-sum_im_ff) : 38'(sum_im_ff);

   always_comb begin
      if (den_ff == '0) coef = 16'd0;
      else if (neg_ff) coef = (num_ff > 53'd32768) ? 16'h8000 : 16'(-num_ff);
      else coef = (num_ff > 53'd32767) ? 16'h7fff : num_ff[15:0];
   end

   assign status.restart    = restart_ff;
   assign status.finished   = finished_ff;
   assign status.settling   = settle_ff != '0;
   assign status.warmup     = count_ff < {8'b0, lag};
   assign status.pass       = pass_ff;
   assign status.last       = formed >= {1'b0, ecount};
   assign status.shift_done = (ar_ff[37:31] == '0) && (ai_ff[37:31] == '0);
   assign status.sqrt_done  = scnt_ff == '0;
   assign status.den_zero   = den_ff == '0;
   assign status.div_done   = dcnt_ff == '0;
   assign status.out_free   = !rvalid_ff || rsp_tready;

   // delay line memory
   always_ff @(posedge clock) begin
      if (cmd.mem_access) begin
         old_ff      <= mem[rd_addr];
         mem[wp_ff]  <= {i_ff, q_ff};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         count_ff    <= '0;
         settle_ff   <= '0;
         finished_ff <= 1'b1;
         sum_re_ff   <= '0;
         sum_im_ff   <= '0;
         sum_mag_ff  <= '0;
         parts_ff    <= '0;
         restart_ff  <= 1'b0;
         rvalid_ff   <= 1'b0;
         scnt_ff     <= '0;
         dcnt_ff     <= '0;
      end else begin
         if (cmd.load) restart_ff <= req_tuser;
         if (cmd.restart) begin
            settle_ff   <= cfg.settle;
            count_ff    <= '0;
            sum_re_ff   <= '0;
            sum_im_ff   <= '0;
            sum_mag_ff  <= '0;
            parts_ff    <= '0;
            finished_ff <= 1'b0;
         end
         if (cmd.settle_dec) settle_ff <= settle_ff - 24'd1;
         if (cmd.mem_access) wp_ff <= wp_ff + 1'b1;
         if (cmd.warm_inc) count_ff <= count_ff + 21'd1;
         if (cmd.acc) begin
            if (pass_ff) begin
               sum_re_ff  <= sum_re_ff + 38'(re_ff);
               sum_im_ff  <= sum_im_ff + 38'(im_ff);
               sum_mag_ff <= sum_mag_ff + {21'b0, sres_ff[15:0]};
               parts_ff   <= parts_ff + 21'd1;
            end
            if (status.last) finished_ff <= 1'b1;
            else if (count_ff != '1) count_ff <= count_ff + 21'd1;
         end
         if (cmd.cmp) scnt_ff <= 6'd16;
         else if (cmd.eadd) scnt_ff <= 6'd32;
         else if (cmd.sqrt_step) scnt_ff <= scnt_ff - 6'd1;
         if (cmd.escale) dcnt_ff <= 6'd53;
         else if (cmd.div_step) dcnt_ff <= dcnt_ff - 6'd1;
         if (cmd.out_load) rvalid_ff <= 1'b1;
         else if (rsp_tready) rvalid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         i_ff <= req_tdata[7:0];
         q_ff <= req_tdata[15:8];
      end
      if (cmd.mul1) begin
         re_ff <= 17'(orr * nr + oi * ni);
         im_ff <= 17'(orr * ni - oi * nr);
      end
      if (cmd.mul2) begin
         rr_ff <= rsq[31:0];
         ii_ff <= isq[31:0];
         mm_ff <= cfg.min_mag * cfg.min_mag;
      end
      if (cmd.cmp) begin
         pass_ff <= (rr_ff + ii_ff) >= mm_ff;
         sx_ff   <= {32'b0, rr_ff + ii_ff};
         sres_ff <= '0;
         sbit_ff <= 64'd1 << 30;
      end else if (cmd.eadd) begin
         sx_ff   <= {1'b0, {1'b0, sqr_ff} + {1'b0, sqi_ff}};
         sres_ff <= '0;
         sbit_ff <= 64'd1 << 62;
      end else if (cmd.sqrt_step) begin
         if (sx_ff >= s_trial) begin
            sx_ff   <= sx_ff - s_trial;
            sres_ff <= (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
         sbit_ff <= sbit_ff >> 2;
      end
      if (cmd.eload) begin
         ar_ff <= abs_re;
         ai_ff <= abs_im;
         sh_ff <= '0;
      end else if (cmd.shift_step) begin
         ar_ff <= ar_ff >> 1;
         ai_ff <= ai_ff >> 1;
         sh_ff <= sh_ff + 3'd1;
      end
      if (cmd.emul) begin
         sqr_ff <= ar_ff[30:0] * ar_ff[30:0];
         sqi_ff <= ai_ff[30:0] * ai_ff[30:0];
      end
      if (cmd.escale) begin
         rem_ff <= '0;
         neg_ff <= 1'b0;
         case (cfg.mode)
            MODE_ABS_TOTAL: begin
               num_ff <= {14'b0, sabs};
               den_ff <= {16'b0, ecount};
            end
            MODE_ABS_PARTS: begin
               num_ff <= {14'b0, sabs};
               den_ff <= {16'b0, parts_ff};
            end
            MODE_ABS_MAGSUM: begin
               num_ff <= {sabs, 14'b0};
               den_ff <= sum_mag_ff;
            end
            default: begin
               num_ff <= {1'b0, abs_re, 14'b0};
               den_ff <= sum_mag_ff;
               neg_ff <= sum_re_ff[37];
            end
         endcase
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            num_ff <= {num_ff[51:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            num_ff <= {num_ff[51:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         rcoef_ff  <= coef;
         rparts_ff <= parts_ff;
         rzero_ff  <= den_ff == '0;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {3'b0, rparts_ff, rcoef_ff};
   assign rsp_tuser  = rzero_ff;

endmodule
`default_nettype wire

[src/lag_autocorrelation_detector.sv]
// ----------------------------------------------------------------------------
// Lag autocorrelation detector
// Delay-and-correlate presence test over a stream of offset-binary IQ bytes.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one IQ byte pair per transfer; tuser set means restart (clears
//    the accumulators, loads the settle counter, the bytes are dropped).
//  rsp channel: one result per run, after product_count lagged products.
//  csr channel: register writes, always ready; write only while idle.
// Throughput: one item at a time. A dropped or warm-up sample is done after
//  load and decode; a product also takes the multiply steps, the compare,
//  the square root when it passes the threshold and the accumulate. The
//  run's closing item adds up to 5 shift steps, a 32-step square root and,
//  unless the denominator is zero, a 53-step restoring divider.
//  The result sits in an output register; the next item is taken while it
//  waits. If the receiver stalls and a new result is ready, the block holds
//  in place until the old result is taken.
// Reset: idle until the first restart; registers return to their defaults;
//  the delay line is not cleared (the warm-up guard keeps unwritten entries
//  from being read).
// ----------------------------------------------------------------------------
`default_nettype none
`include "lag_autocorrelation_detector_defines.svh"
module lag_autocorrelation_detector (
   input  wire         clock,
   input  wire         reset,
   // input samples
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [7:0] i_raw, [15:8] q_raw
   input  wire         req_tuser,   // [0] restart
   // results
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] coefficient, [36:16] parts_counted
   output logic        rsp_tuser,   // [0] zero_denominator
   // register writes
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [23:0] csr_data
);
   import lad_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // register file; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lag     <= 13'd2048;
         cfg_ff.count   <= 21'd409600;
         cfg_ff.settle  <= 24'd204800;
         cfg_ff.min_mag <= 16'd512;
         cfg_ff.mode    <= MODE_RE_MAGSUM;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LAG:     cfg_ff.lag     <= csr_data[12:0];
            REG_COUNT:   cfg_ff.count   <= csr_data[20:0];
            REG_SETTLE:  cfg_ff.settle  <= csr_data;
            REG_MIN_MAG: cfg_ff.min_mag <= csr_data[15:0];
            REG_MODE:    cfg_ff.mode    <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   lad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lad_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a pending result is never overwritten
   `LAD_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.out_load, status.out_free)
   // divider never runs on a zero denominator
   `LAD_ASSERT_IMPL(a_div_nonzero, clock, reset, cmd.div_step, !status.den_zero)
   // a result appears only after the controller loads it
   `LAD_ASSERT_NEXT(a_out_source, clock, reset, !rsp_tvalid && !cmd.out_load, !rsp_tvalid)

endmodule
`default_nettype wire
